/* rtl/smad_pkg.sv */
// ----------------------------------------------------------------------------
// smad_pkg
// Shared constants and types for the smoothed servo angle block
// ----------------------------------------------------------------------------
package smad_pkg;

	localparam int SAMPLE_W         = 10;
	localparam int SAMPLES_PER_ITEM = 3;
	localparam int WINDOW_LEN       = 20;
	localparam int ANGLE_W          = 8;
	localparam int KEPT_W           = 2;

	localparam int ADC_MAX      = 1023;
	localparam int ANGLE_MAX    = 180;
	localparam int ANGLE_CENTER = 90;

	localparam int REJECT_RESET   = 5;
	localparam int DEADBAND_RESET = 5;

	localparam int ACC_W  = $clog2(SAMPLES_PER_ITEM * ADC_MAX + 1);
	localparam int SUM_W  = $clog2(WINDOW_LEN * ADC_MAX + 1);
	localparam int SLOT_W = $clog2(WINDOW_LEN);
	localparam int DIV_W  = $clog2(ADC_MAX * ANGLE_MAX + 1);
	localparam int CNT_W  = $clog2(DIV_W + 1);

	localparam int IN_BITS  = SAMPLES_PER_ITEM * SAMPLE_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = ANGLE_W + 2 + SAMPLE_W + KEPT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = SAMPLE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_REJECT_LEVEL = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = CFG_IDX_W'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MEAN,
		S_AVG,
		S_ANGLE,
		S_DONE
	} state_t;

endpackage

/* rtl/smoothed_servo_angle_deadband_top.sv */
// ----------------------------------------------------------------------------
// smoothed_servo_angle_deadband_top
// Sample rejection, 20-entry moving average and deadband angle hold
// ----------------------------------------------------------------------------
// Input stream (s_axis_*): one transaction carries three 10-bit ADC samples.
// Output stream (m_axis_*): one transaction per input transaction with the
// held angle, moved and no_valid flags, window average and kept count.
// Configuration: cfg_we writes reject_level (index 0) or deadband (index 1)
// from cfg_wdata; the user writes only while the block is idle (not enforced).
// All arithmetic runs through one shared restoring divider that takes one
// quotient bit per cycle: mean (12 bits), window average (15 bits) and
// angle (18 bits). An item with kept samples runs the mean, average and
// angle divisions in turn; an item with all samples rejected skips them.
// A new item is taken only once the last result is in the output register.
// The result sits in an output register; while the receiver stalls the
// block still works on the following item and then waits with it.
// Reset: window empty and unprimed, held angle 90, registers at 5 and 5.
// ----------------------------------------------------------------------------
module smoothed_servo_angle_deadband_top
	import smad_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_W-1:0]       s_axis_tdata,  // sample_a, sample_b, sample_c
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata,  // servo_angle, moved, no_valid,
	                                             // window_average, kept_count
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	state_t state_q, state_d;

	logic [SAMPLE_W-1:0] reject_q;
	logic [ANGLE_W-1:0]  deadband_q;

	logic [SAMPLE_W-1:0] window_q [WINDOW_LEN];
	logic [SUM_W-1:0]    window_sum_q;
	logic [SLOT_W-1:0]   write_slot_q;
	logic                primed_q;
	logic [ANGLE_W-1:0]  held_angle_q;
	logic [SAMPLE_W-1:0] avg_q;
	logic                moved_q;
	logic                no_valid_q;
	logic [KEPT_W-1:0]   kept_q;

	logic [SAMPLE_W-1:0] div_rem_q;
	logic [DIV_W-1:0]    div_quo_q;
	logic [SAMPLE_W-1:0] div_den_q;
	logic [CNT_W-1:0]    div_cnt_q;

	logic [ACC_W-1:0]    acc;
	logic [KEPT_W-1:0]   kept;
	logic                accept;
	logic                take_mean;
	logic                take_avg;
	logic                take_angle;
	logic                out_load;
	logic                div_load;
	logic [DIV_W-1:0]    div_dividend;
	logic [SAMPLE_W-1:0] div_den;
	logic [CNT_W-1:0]    div_bits;

	logic [SAMPLE_W:0]   trial;
	logic                trial_ge;
	logic [SAMPLE_W:0]   trial_diff;

	logic [SAMPLE_W-1:0] mean;
	logic [SAMPLE_W-1:0] old_entry;
	logic [SUM_W-1:0]    sum_base;
	logic [SUM_W-1:0]    new_sum;
	logic [SAMPLE_W-1:0] avg;
	logic [ANGLE_W-1:0]  angle;
	logic [ANGLE_W-1:0]  angle_diff;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	// kept samples and their sum
	always_comb begin
		logic [SAMPLE_W-1:0] s;
		acc  = '0;
		kept = '0;
		for (int i = 0; i < SAMPLES_PER_ITEM; i++) begin
			s = s_axis_tdata[i*SAMPLE_W +: SAMPLE_W];
			if (s > reject_q) begin
				acc  = acc + ACC_W'(s);
				kept = kept + KEPT_W'(1);
			end
		end
	end

	// window update from the mean
	assign mean       = div_quo_q[SAMPLE_W-1:0];
	assign old_entry  = primed_q ? window_q[write_slot_q] : mean;
	assign sum_base   = primed_q ? window_sum_q : SUM_W'(mean) * SUM_W'(WINDOW_LEN);
	assign new_sum    = sum_base - SUM_W'(old_entry) + SUM_W'(mean);
	assign avg        = div_quo_q[SAMPLE_W-1:0];
	assign angle      = div_quo_q[ANGLE_W-1:0];
	assign angle_diff = (angle > held_angle_q) ? angle - held_angle_q : held_angle_q - angle;

	// divider step: one quotient bit per cycle
	assign trial      = {div_rem_q, div_quo_q[DIV_W-1]};
	assign trial_ge   = trial >= {1'b0, div_den_q};
	assign trial_diff = trial - {1'b0, div_den_q};

	always_comb begin
		state_d      = state_q;
		take_mean    = 1'b0;
		take_avg     = 1'b0;
		take_angle   = 1'b0;
		out_load     = 1'b0;
		div_load     = 1'b0;
		div_dividend = DIV_W'(acc) << (DIV_W - ACC_W);
		div_den      = SAMPLE_W'(kept);
		div_bits     = CNT_W'(ACC_W);
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (kept == '0) begin
						state_d = S_DONE;
					end else begin
						div_load = 1'b1;
						state_d  = S_MEAN;
					end
				end
			end
			S_MEAN: begin
				if (div_cnt_q == '0) begin
					take_mean    = 1'b1;
					div_load     = 1'b1;
					div_dividend = DIV_W'(new_sum) << (DIV_W - SUM_W);
					div_den      = SAMPLE_W'(WINDOW_LEN);
					div_bits     = CNT_W'(SUM_W);
					state_d      = S_AVG;
				end
			end
			S_AVG: begin
				if (div_cnt_q == '0) begin
					take_avg     = 1'b1;
					div_load     = 1'b1;
					div_dividend = DIV_W'(avg) * DIV_W'(ANGLE_MAX);
					div_den      = SAMPLE_W'(ADC_MAX);
					div_bits     = CNT_W'(DIV_W);
					state_d      = S_ANGLE;
				end
			end
			S_ANGLE: begin
				if (div_cnt_q == '0) begin
					take_angle = 1'b1;
					state_d    = S_DONE;
				end
			end
			S_DONE: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and held state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_q      <= SAMPLE_W'(REJECT_RESET);
			deadband_q    <= ANGLE_W'(DEADBAND_RESET);
			window_sum_q  <= '0;
			write_slot_q  <= '0;
			primed_q      <= 1'b0;
			held_angle_q  <= ANGLE_W'(ANGLE_CENTER);
			avg_q         <= '0;
			div_cnt_q     <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_REJECT_LEVEL: reject_q   <= cfg_wdata;
					CFG_DEADBAND:     deadband_q <= cfg_wdata[ANGLE_W-1:0];
					default: ;
				endcase
			end
			if (take_mean) begin
				window_sum_q <= new_sum;
				primed_q     <= 1'b1;
				write_slot_q <= (write_slot_q == SLOT_W'(WINDOW_LEN - 1)) ?
				                '0 : write_slot_q + SLOT_W'(1);
			end
			if (take_avg) begin
				avg_q <= avg;
			end
			if (take_angle && (angle_diff >= deadband_q)) begin
				held_angle_q <= angle;
			end
			if (div_load) begin
				div_cnt_q <= div_bits;
			end else if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - CNT_W'(1);
			end
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// payload: window entries, divider shift registers, result fields
	always_ff @(posedge clk) begin
		if (take_mean) begin
			if (!primed_q) begin
				for (int i = 0; i < WINDOW_LEN; i++) begin
					window_q[i] <= mean;
				end
			end else begin
				window_q[write_slot_q] <= mean;
			end
		end
		if (div_load) begin
			div_rem_q <= '0;
			div_quo_q <= div_dividend;
			div_den_q <= div_den;
		end else if (div_cnt_q != '0) begin
			div_rem_q <= trial_ge ? trial_diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
			div_quo_q <= {div_quo_q[DIV_W-2:0], trial_ge};
		end
		if (accept) begin
			kept_q     <= kept;
			no_valid_q <= (kept == '0);
			moved_q    <= 1'b0;
		end
		if (take_angle) begin
			moved_q <= (angle_diff >= deadband_q) && (angle != held_angle_q);
		end
		if (out_load) begin
			m_axis_tdata <= OUT_W'({kept_q, avg_q, no_valid_q, moved_q, held_angle_q});
		end
	end

	a_div_in_divide_states: assert property (@(posedge clk) disable iff (!arst_n)
		(div_cnt_q != '0) |-> (state_q == S_MEAN || state_q == S_AVG || state_q == S_ANGLE))
		else $error("divider busy outside a divide state");

	a_held_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_angle_q <= ANGLE_W'(ANGLE_MAX))
		else $error("held angle out of range");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		write_slot_q <= SLOT_W'(WINDOW_LEN - 1))
		else $error("write slot out of range");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		window_sum_q <= SUM_W'(WINDOW_LEN * ADC_MAX))
		else $error("window sum out of range");

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_MEAN || state_q == S_DONE))
		else $error("accepted transaction not taken up");

endmodule

/* bench/tb_smoothed_servo_angle_deadband_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smoothed_servo_angle_deadband_top
// Self-checking bench for the smoothed servo angle block
// ----------------------------------------------------------------------------
// Drives three-sample items into the input stream and follows the block with
// its own model of sample rejection, window priming, the 20-entry moving
// average, the angle mapping and the deadband hold. Each output transaction
// is checked field by field against the oldest predicted result. Directed
// tests cover the field extremes, priming, all-rejected items and the
// register extremes. Random phases then run a drifting crank with glitches
// under several idle and stall mixes, plus a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_smoothed_servo_angle_deadband_top;
	import smad_pkg::*;

	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_ITEMS  = 450;
	localparam int CFG_INTERVAL = 150;

	typedef struct {
		logic [ANGLE_W-1:0]  angle;
		logic                moved;
		logic                no_valid;
		logic [SAMPLE_W-1:0] avg;
		logic [KEPT_W-1:0]   kept;
	} servo_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// tracked block state
	int unsigned win_store [WINDOW_LEN];
	int unsigned win_sum;
	int unsigned wr_slot;
	int unsigned held_angle;
	bit          primed;
	int unsigned reject_level;
	int unsigned deadband;

	servo_result_t servo_results_due[$];
	servo_result_t seen;
	servo_result_t want;

	int unsigned src_idle_pct;
	int unsigned sink_stall_pct;
	int unsigned hold_cycles_req;
	int          crank_pos;
	int          mismatches;
	int          idle_cycles;
	int          items_sent;
	int          no_valid_seen;
	int          moves_seen;
	int          reg_writes;

	smoothed_servo_angle_deadband_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	task automatic compute_servo_step(input logic [SAMPLE_W-1:0] sa, sb, sc);
		int unsigned acc;
		int unsigned kept;
		int unsigned mean;
		int unsigned avg;
		int unsigned angle;
		int unsigned diff;
		int unsigned smp [SAMPLES_PER_ITEM];
		servo_result_t r;
		acc = 0;
		kept = 0;
		smp[0] = sa;
		smp[1] = sb;
		smp[2] = sc;
		for (int i = 0; i < SAMPLES_PER_ITEM; i++) begin
			if (smp[i] > reject_level) begin
				acc += smp[i];
				kept++;
			end
		end
		r.moved = 1'b0;
		if (kept == 0) begin
			r.angle    = ANGLE_W'(held_angle);
			r.no_valid = 1'b1;
			r.avg      = SAMPLE_W'(win_sum / WINDOW_LEN);
			r.kept     = '0;
		end else begin
			mean = acc / kept;
			if (!primed) begin
				for (int i = 0; i < WINDOW_LEN; i++)
					win_store[i] = mean;
				win_sum = mean * WINDOW_LEN;
				primed = 1'b1;
			end
			if (wr_slot >= WINDOW_LEN)
				wr_slot = 0;
			win_sum = win_sum - win_store[wr_slot] + mean;
			win_store[wr_slot] = mean;
			wr_slot = (wr_slot + 1) % WINDOW_LEN;
			avg = win_sum / WINDOW_LEN;
			if (avg > ADC_MAX)
				avg = ADC_MAX;
			angle = avg * ANGLE_MAX / ADC_MAX;
			if (angle > ANGLE_MAX)
				angle = ANGLE_MAX;
			diff = (angle > held_angle) ? angle - held_angle : held_angle - angle;
			if (diff >= deadband) begin
				r.moved = (angle != held_angle);
				held_angle = angle;
			end
			r.angle    = ANGLE_W'(held_angle);
			r.no_valid = 1'b0;
			r.avg      = SAMPLE_W'(avg);
			r.kept     = KEPT_W'(kept);
		end
		servo_results_due.push_back(r);
	endtask

	// called right after a falling edge, returns right after one
	task automatic send_samples(input logic [SAMPLE_W-1:0] sa, sb, sc);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tdata  = IN_W'({sc, sb, sa});
		s_axis_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		compute_servo_step(sa, sb, sc);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		s_axis_tvalid = 1'b0;
		while (servo_results_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = CFG_DATA_W'(value);
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_REJECT_LEVEL)
			reject_level = value & 32'h3FF;
		else
			deadband = value & 32'hFF;
		reg_writes++;
	endtask

	function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
		if (v < 0)
			return '0;
		if (v > ADC_MAX)
			return SAMPLE_W'(ADC_MAX);
		return SAMPLE_W'(v);
	endfunction

	// slowly turning crank with occasional glitches, jumps and dropouts
	task automatic make_crank_item(output logic [SAMPLE_W-1:0] sa, sb, sc);
		int unsigned mode;
		int unsigned lvl;
		logic [SAMPLE_W-1:0] smp [SAMPLES_PER_ITEM];
		mode = $urandom_range(19);
		lvl = (reject_level < ADC_MAX) ? reject_level : ADC_MAX;
		for (int i = 0; i < SAMPLES_PER_ITEM; i++) begin
			case (mode)
				0, 1: begin
					smp[i] = SAMPLE_W'($urandom);
				end
				2: begin
					smp[i] = SAMPLE_W'($urandom_range(lvl));
				end
				3: begin
					case ($urandom_range(3))
						0: smp[i] = '0;
						1: smp[i] = SAMPLE_W'(ADC_MAX);
						2: smp[i] = SAMPLE_W'(lvl);
						default: smp[i] = clamp_sample(lvl + 1);
					endcase
				end
				default: begin
					if ($urandom_range(7) == 0)
						smp[i] = SAMPLE_W'($urandom_range(lvl));
					else
						smp[i] = clamp_sample(crank_pos + $urandom_range(16) - 8);
				end
			endcase
		end
		if ($urandom_range(49) == 0)
			crank_pos = $urandom_range(ADC_MAX);
		else
			crank_pos = clamp_sample(crank_pos + $urandom_range(60) - 30);
		sa = smp[0];
		sb = smp[1];
		sc = smp[2];
	endtask

	task automatic pick_random_config();
		settle();
		if ($urandom_range(3) == 0)
			write_reg(CFG_REJECT_LEVEL, $urandom_range(ADC_MAX));
		else
			write_reg(CFG_REJECT_LEVEL, $urandom_range(60));
		if ($urandom_range(4) == 0)
			write_reg(CFG_DEADBAND, $urandom_range(255));
		else
			write_reg(CFG_DEADBAND, $urandom_range(12));
	endtask

	task automatic test_priming_and_extremes();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		send_samples(10'd0, 10'd0, 10'd0);
		send_samples(10'd1, 10'd5, 10'd3);
		send_samples(10'd1023, 10'd1023, 10'd1023);
		send_samples(10'd6, 10'd0, 10'd0);
		send_samples(10'd1023, 10'd0, 10'd1023);
		send_samples(10'd0, 10'd0, 10'd0);
		send_samples(10'd512, 10'd513, 10'd514);
		send_samples(10'h2AA, 10'h155, 10'h2AA);
		send_samples(10'h155, 10'h2AA, 10'h155);
		send_samples(10'd1023, 10'd6, 10'd1023);
		send_samples(10'd5, 10'd1023, 10'd5);
	endtask

	task automatic test_deadband_edges();
		settle();
		write_reg(CFG_DEADBAND, 0);
		send_samples(10'd300, 10'd300, 10'd300);
		send_samples(10'd300, 10'd300, 10'd300);
		settle();
		write_reg(CFG_DEADBAND, ANGLE_MAX);
		send_samples(10'd0, 10'd6, 10'd0);
		send_samples(10'd1023, 10'd1023, 10'd1023);
		settle();
		write_reg(CFG_DEADBAND, 200);
		send_samples(10'd6, 10'd6, 10'd6);
		settle();
		write_reg(CFG_DEADBAND, 255);
		send_samples(10'd1023, 10'd1023, 10'd1023);
	endtask

	task automatic test_reject_edges();
		settle();
		write_reg(CFG_REJECT_LEVEL, 0);
		write_reg(CFG_DEADBAND, 1);
		send_samples(10'd0, 10'd1, 10'd0);
		send_samples(10'd0, 10'd0, 10'd0);
		settle();
		write_reg(CFG_REJECT_LEVEL, ADC_MAX);
		send_samples(10'd1023, 10'd1023, 10'd1023);
		settle();
		write_reg(CFG_REJECT_LEVEL, ADC_MAX - 1);
		send_samples(10'd1022, 10'd1023, 10'd0);
		send_samples(10'd1023, 10'd1023, 10'd1023);
	endtask

	task automatic test_crank_phase(input int unsigned idle_pct, input int unsigned stall_pct);
		logic [SAMPLE_W-1:0] sa, sb, sc;
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i % CFG_INTERVAL == 0)
				pick_random_config();
			make_crank_item(sa, sb, sc);
			send_samples(sa, sb, sc);
		end
	endtask

	task automatic test_output_hold_off();
		logic [SAMPLE_W-1:0] sa, sb, sc;
		settle();
		write_reg(CFG_REJECT_LEVEL, REJECT_RESET);
		write_reg(CFG_DEADBAND, DEADBAND_RESET);
		src_idle_pct    = 0;
		sink_stall_pct  = 0;
		hold_cycles_req = HOLD_CYCLES;
		for (int i = 0; i < 30; i++) begin
			make_crank_item(sa, sb, sc);
			send_samples(sa, sb, sc);
		end
		settle();
	endtask

	// receiver side
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles_req != 0) begin
				m_axis_tready = 1'b0;
				repeat (hold_cycles_req) @(negedge clk);
				hold_cycles_req = 0;
			end
			m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.angle    = m_axis_tdata[ANGLE_W-1:0];
			seen.moved    = m_axis_tdata[ANGLE_W];
			seen.no_valid = m_axis_tdata[ANGLE_W+1];
			seen.avg      = m_axis_tdata[ANGLE_W+2 +: SAMPLE_W];
			seen.kept     = m_axis_tdata[ANGLE_W+2+SAMPLE_W +: KEPT_W];
			no_valid_seen += seen.no_valid;
			moves_seen    += seen.moved;
			if (servo_results_due.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual %h",
					$time, m_axis_tdata);
				mismatches++;
			end else begin
				want = servo_results_due.pop_front();
				if (seen.angle !== want.angle) begin
					$display("%0t: servo_angle expected %0d actual %0d",
						$time, want.angle, seen.angle);
					mismatches++;
				end
				if (seen.moved !== want.moved) begin
					$display("%0t: moved expected %0d actual %0d",
						$time, want.moved, seen.moved);
					mismatches++;
				end
				if (seen.no_valid !== want.no_valid) begin
					$display("%0t: no_valid expected %0d actual %0d",
						$time, want.no_valid, seen.no_valid);
					mismatches++;
				end
				if (seen.avg !== want.avg) begin
					$display("%0t: window_average expected %0d actual %0d",
						$time, want.avg, seen.avg);
					mismatches++;
				end
				if (seen.kept !== want.kept) begin
					$display("%0t: kept_count expected %0d actual %0d",
						$time, want.kept, seen.kept);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results outstanding",
					$time, IDLE_LIMIT, servo_results_due.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		s_axis_tvalid   = 1'b0;
		s_axis_tdata    = '0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_wdata       = '0;
		src_idle_pct    = 0;
		sink_stall_pct  = 0;
		hold_cycles_req = 0;
		crank_pos       = ADC_MAX / 2;
		mismatches      = 0;
		idle_cycles     = 0;
		items_sent      = 0;
		no_valid_seen   = 0;
		moves_seen      = 0;
		reg_writes      = 0;
		for (int i = 0; i < WINDOW_LEN; i++)
			win_store[i] = 0;
		win_sum      = 0;
		wr_slot      = 0;
		held_angle   = ANGLE_CENTER;
		primed       = 1'b0;
		reject_level = REJECT_RESET;
		deadband     = DEADBAND_RESET;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_priming_and_extremes();
		test_deadband_edges();
		test_reject_edges();
		test_crank_phase(0, 0);
		test_crank_phase(69, 0);
		test_crank_phase(0, 69);
		test_crank_phase(9, 9);
		test_output_hold_off();

		settle();
		repeat (60) @(posedge clk);
		$display("run covered %0d items, %0d with every sample rejected, %0d angle moves",
			items_sent, no_valid_seen, moves_seen);
		$display("%0d register writes across directed, random and hold-off phases",
			reg_writes);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* smoothed_servo_angle_deadband_top.f */
rtl/smad_pkg.sv
rtl/smoothed_servo_angle_deadband_top.sv
bench/tb_smoothed_servo_angle_deadband_top.sv
